/* rtl/core/mssm_pkg.sv */
// Package for the shared-memory multi-stack unit.
// Holds sizes, operation and status codes, control structs and word helpers.
// No dependencies.
package mssm_pkg;

    // Sizes of the stack array.
    localparam int NUM_STACKS  = 3;
    localparam int STACK_DEPTH = 32;
    localparam int DATA_WIDTH  = 32;

    localparam int MEM_DEPTH = NUM_STACKS * STACK_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int CNT_W     = $clog2(STACK_DEPTH + 1);

    // Field widths of the item channels.
    localparam int OP_W  = 2;
    localparam int SEL_W = 2;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_W-1:0] OP_POP  = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic exec;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_valid;
        logic out_ready;
    } t_dp_sts;

    // A pushed value is sign-extended from 32 bits and kept in a word.
    function automatic logic [DATA_WIDTH-1:0] to_word(input logic [VAL_W-1:0] v);
        return DATA_WIDTH'(signed'(v));
    endfunction

    // A stored word is sign-extended and given in 32 bits.
    function automatic logic [VAL_W-1:0] from_word(input logic [DATA_WIDTH-1:0] w);
        return VAL_W'(signed'(w));
    endfunction

endpackage

/* rtl/core/mssm_if.sv */
// Valid/ready channel interfaces for the multi-stack unit.
// Depends on mssm_pkg for field widths.

// Request channel: one stack operation per item.
interface mssm_req_if
    import mssm_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic        [OP_W-1:0]  opcode;
    logic        [SEL_W-1:0] stack_select;
    logic signed [VAL_W-1:0] push_value;

    modport source (output valid, opcode, stack_select, push_value, input ready);
    modport sink   (input valid, opcode, stack_select, push_value, output ready);
endinterface

// Response channel: one result per item.
interface mssm_rsp_if
    import mssm_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] read_value;
    logic        [ST_W-1:0]  status;
    logic                    now_empty;

    modport source (output valid, read_value, status, now_empty, input ready);
    modport sink   (input valid, read_value, status, now_empty, output ready);
endinterface

/* rtl/core/multi_stack_shared_memory_unit.sv */
// An accepted item is captured, then the execute step reads or writes the stack memory,
// and the result moves to the output register once that register is free; a waiting
// result stalls the next one, and no new item is taken until the last is handed off.
// Reset (synchronous, active low) empties every stack and the output register;
// the stack memory is not cleared and needs no clearing pass.
// Top level of the multi-stack unit; depends on mssm_pkg, mssm_if, mssm_ctrl, mssm_dp.
module multi_stack_shared_memory_unit
    import mssm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    mssm_req_if.sink    i_req,
    mssm_rsp_if.source  o_rsp
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Controller.
    mssm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_sts       (sts),
        .o_req_ready (i_req.ready),
        .o_cmd       (cmd)
    );

    // Datapath.
    mssm_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_opcode       (i_req.opcode),
        .i_stack_select (i_req.stack_select),
        .i_push_value   (i_req.push_value),
        .o_valid        (o_rsp.valid),
        .i_ready        (o_rsp.ready),
        .o_read_value   (o_rsp.read_value),
        .o_status       (o_rsp.status),
        .o_now_empty    (o_rsp.now_empty)
    );

endmodule

/* rtl/core/mssm_ctrl.sv */
// Controller state machine of the multi-stack unit.
// Sequences capture, execute and result hand-off; uses mssm_pkg structs.
module mssm_ctrl
    import mssm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    input  t_dp_sts i_sts,
    output logic    o_req_ready,
    output t_dp_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       slot_free;

    // The result slot is free when empty or being drained this cycle.
    assign slot_free = !i_sts.out_valid || i_sts.out_ready;

    // Next state and commands.
    always_comb begin
        n_state        = r_state;
        o_req_ready    = 1'b0;
        o_cmd.load_in  = 1'b0;
        o_cmd.exec     = 1'b0;
        o_cmd.load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/core/mssm_dp.sv */
// Datapath of the multi-stack unit: item registers, fill counts,
// shared stack memory and the result register. Uses mssm_pkg.
module mssm_dp
    import mssm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    output t_dp_sts                 o_sts,
    input  logic        [OP_W-1:0]  i_opcode,
    input  logic        [SEL_W-1:0] i_stack_select,
    input  logic signed [VAL_W-1:0] i_push_value,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [VAL_W-1:0] o_read_value,
    output logic        [ST_W-1:0]  o_status,
    output logic                    o_now_empty
);

    // Captured item.
    logic [OP_W-1:0]  r_op;
    logic [SEL_W-1:0] r_sel;
    logic [VAL_W-1:0] r_val;

    // Per-stack fill counts.
    logic [CNT_W-1:0] r_counts [NUM_STACKS];

    // Shared stack memory and its registered read port.
    logic [DATA_WIDTH-1:0] mem [MEM_DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    // Results of the execute step.
    logic [ST_W-1:0] r_res_status;
    logic            r_res_empty;
    logic            r_res_use_rd;

    // Result register.
    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_out_value;
    logic        [ST_W-1:0]  r_out_status;
    logic                    r_out_empty;

    logic             found;
    logic [CNT_W-1:0] cur_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [CNT_W-1:0] offset;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] addr;
    logic [ST_W-1:0]  status;
    logic             use_rd;
    logic             do_write;
    logic             n_empty;

    // Select the addressed stack's count and region base.
    always_comb begin
        found   = 1'b0;
        cur_cnt = '0;
        base    = '0;
        for (int i = 0; i < NUM_STACKS; i++) begin
            if (int'(r_sel) == i) begin
                found   = 1'b1;
                cur_cnt = r_counts[i];
                base    = ADDR_W'(i * STACK_DEPTH);
            end
        end
    end

    // Decide the operation outcome and the new count.
    always_comb begin
        n_cnt    = cur_cnt;
        status   = ST_OK;
        use_rd   = 1'b0;
        do_write = 1'b0;
        if (found) begin
            unique case (r_op)
                OP_PUSH: begin
                    if (cur_cnt == CNT_W'(STACK_DEPTH)) begin
                        status = ST_FULL;
                    end else begin
                        do_write = 1'b1;
                        n_cnt    = cur_cnt + 1'b1;
                    end
                end
                OP_POP: begin
                    if (cur_cnt == '0) begin
                        status = ST_EMPTY;
                    end else begin
                        use_rd = 1'b1;
                        n_cnt  = cur_cnt - 1'b1;
                    end
                end
                OP_PEEK: begin
                    if (cur_cnt == '0) begin
                        status = ST_EMPTY;
                    end else begin
                        use_rd = 1'b1;
                    end
                end
                default: begin
                    n_cnt = cur_cnt;
                end
            endcase
        end
        n_empty = found ? (n_cnt == '0) : 1'b1;
    end

    // A push writes just above the top; a pop or peek reads the top.
    assign offset = (r_op == OP_PUSH) ? cur_cnt : cur_cnt - 1'b1;
    assign addr   = base + ADDR_W'(offset);

    // Item capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op  <= i_opcode;
            r_sel <= i_stack_select;
            r_val <= i_push_value;
        end
    end

    // Fill counts, cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_STACKS; i++) begin
                r_counts[i] <= '0;
            end
        end else if (i_cmd.exec) begin
            for (int i = 0; i < NUM_STACKS; i++) begin
                if (int'(r_sel) == i) begin
                    r_counts[i] <= n_cnt;
                end
            end
        end
    end

    // Stack memory: one write or one read per execute step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && do_write) begin
            mem[addr] <= to_word(r_val);
        end
        if (i_cmd.exec && use_rd) begin
            r_rdata <= mem[addr];
        end
    end

    // Hold the execute outcome until the read data is available.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res_status <= status;
            r_res_empty  <= n_empty;
            r_res_use_rd <= use_rd;
        end
    end

    // Result register with its valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_value  <= r_res_use_rd ? from_word(r_rdata) : '0;
            r_out_status <= r_res_status;
            r_out_empty  <= r_res_empty;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_read_value  = r_out_value;
    assign o_status      = r_out_status;
    assign o_now_empty   = r_out_empty;
    assign o_sts.out_valid = r_out_valid;
    assign o_sts.out_ready = i_ready;

endmodule

/* tb/sv/multi_stack_shared_memory_unit_test.sv */
`timescale 1ns / 1ps
// Testbench for the shared-memory multi-stack unit: directed table, then random episodes.
// Depends on mssm_pkg, mssm_if and the multi_stack_shared_memory_unit top level.
module multi_stack_shared_memory_unit_test;
    import mssm_pkg::*;

    // Opcode that the unit treats as no operation, and the first missing stack number.
    localparam logic [OP_W-1:0]  OP_NONE     = 2'd3;
    localparam logic [SEL_W-1:0] SEL_MISSING = SEL_W'(NUM_STACKS);
    localparam int               CYCLE_LIMIT = 200000;
    localparam int               RANDOM_OPS  = 1600;
    localparam int               HOLD_LEN    = 80;

    // One result of the unit.
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [ST_W-1:0]  st;
        logic             emp;
    } t_stack_reply;

    // One row of the directed table; reps repeats the row with the value counting up.
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [SEL_W-1:0] sel;
        logic [VAL_W-1:0] val;
        int               reps;
        logic             typed;
        t_stack_reply     want;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mssm_req_if req_ch ();
    mssm_rsp_if rsp_ch ();

    multi_stack_shared_memory_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Shadow copy of the stacks.
    logic signed [DATA_WIDTH-1:0] stack_words [NUM_STACKS][STACK_DEPTH];
    int unsigned                  stack_fill  [NUM_STACKS];

    t_stack_reply pending_replies [$];
    int           error_count = 0;
    int           cycle_count = 0;
    int           idle_pct    = 0;
    int           hold_cycles = 0;
    int           ops_done    = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Applies one operation to the shadow stacks and returns the result it causes.
    function automatic t_stack_reply apply_stack_op(input logic [OP_W-1:0] op,
                                                    input logic [SEL_W-1:0] sel,
                                                    input logic [VAL_W-1:0] val);
        t_stack_reply                 r;
        logic signed [DATA_WIDTH-1:0] word;
        logic signed [VAL_W-1:0]      wide;
        int unsigned                  n;
        r = '{value: '0, st: ST_OK, emp: 1'b1};
        if (sel < NUM_STACKS) begin
            n = stack_fill[sel];
            if (op == OP_PUSH) begin
                if (n >= STACK_DEPTH) begin
                    r.st = ST_FULL;
                end else begin
                    word = $signed(val);
                    stack_words[sel][n] = word;
                    n++;
                end
            end else if (op == OP_POP || op == OP_PEEK) begin
                if (n == 0) begin
                    r.st = ST_EMPTY;
                end else begin
                    wide    = stack_words[sel][n-1];
                    r.value = wide;
                    if (op == OP_POP) n--;
                end
            end
            stack_fill[sel] = n;
            r.emp = (n == 0);
        end
        return r;
    endfunction

    // Random push value, with the extremes showing up often.
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Offers one item, possibly after a short gap, and records its expected result
    // once it is accepted. Returns at the accepting edge with valid still high.
    task automatic send_op(input logic [OP_W-1:0] op, input logic [SEL_W-1:0] sel,
                           input logic [VAL_W-1:0] val, input logic typed,
                           input t_stack_reply want);
        t_stack_reply got;
        if ($urandom_range(0, 99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.opcode       <= op;
        req_ch.stack_select <= sel;
        req_ch.push_value   <= val;
        do @(posedge i_clk); while (!req_ch.ready);
        got = apply_stack_op(op, sel, val);
        pending_replies.push_back(typed ? want : got);
        if (op <= OP_PEEK && sel < NUM_STACKS) ops_done++;
    endtask

    task automatic send_random(input logic [OP_W-1:0] op, input logic [SEL_W-1:0] sel);
        send_op(op, sel, pick_value(), 1'b0, '0);
    endtask

    // Receiver side: random stall bursts, plus one long hold when asked for.
    initial begin : rsp_side
        int n;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                n = hold_cycles;
                hold_cycles = 0;
                rsp_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else if ($urandom_range(0, 99) < idle_pct) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        t_stack_reply exp_r;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: result with nothing expected: value %h status %0d empty %0b",
                         $time, rsp_ch.read_value, rsp_ch.status, rsp_ch.now_empty);
                error_count++;
            end else begin
                exp_r = pending_replies.pop_front();
                if (rsp_ch.read_value !== exp_r.value) begin
                    $display("%0t: read_value expected %h actual %h",
                             $time, exp_r.value, rsp_ch.read_value);
                    error_count++;
                end
                if (rsp_ch.status !== exp_r.st) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_r.st, rsp_ch.status);
                    error_count++;
                end
                if (rsp_ch.now_empty !== exp_r.emp) begin
                    $display("%0t: now_empty expected %0b actual %0b",
                             $time, exp_r.emp, rsp_ch.now_empty);
                    error_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[multi_stack_shared_memory_unit] ERROR");
            $finish;
        end
    end

    // Main sequence.
    initial begin : main_seq
        t_stim_row directed [0:22];
        int        kind;
        int        n;
        logic [SEL_W-1:0] s;
        logic [OP_W-1:0]  op;
        bit        held;
        bit        drained;

        i_rst_n             <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.opcode       <= OP_PUSH;
        req_ch.stack_select <= '0;
        req_ch.push_value   <= '0;
        foreach (stack_fill[k]) stack_fill[k] = 0;

        directed = '{
            // Every stack starts empty.
            '{OP_POP,  2'd0, 32'h0, 1, 1'b1, '{32'h0, ST_EMPTY, 1'b1}},
            '{OP_PEEK, 2'd1, 32'h0, 1, 1'b1, '{32'h0, ST_EMPTY, 1'b1}},
            '{OP_PEEK, 2'd2, 32'h0, 1, 1'b1, '{32'h0, ST_EMPTY, 1'b1}},
            // Extreme values come back in reverse order.
            '{OP_PUSH, 2'd0, 32'h7FFF_FFFF, 1, 1'b1, '{32'h0, ST_OK, 1'b0}},
            '{OP_PUSH, 2'd0, 32'h8000_0000, 1, 1'b1, '{32'h0, ST_OK, 1'b0}},
            '{OP_PEEK, 2'd0, 32'h0, 1, 1'b1, '{32'h8000_0000, ST_OK, 1'b0}},
            '{OP_POP,  2'd0, 32'h0, 1, 1'b1, '{32'h8000_0000, ST_OK, 1'b0}},
            '{OP_POP,  2'd0, 32'h0, 1, 1'b1, '{32'h7FFF_FFFF, ST_OK, 1'b1}},
            '{OP_POP,  2'd0, 32'h0, 1, 1'b1, '{32'h0, ST_EMPTY, 1'b1}},
            '{OP_PUSH, 2'd1, 32'hFFFF_FFFF, 1, 1'b1, '{32'h0, ST_OK, 1'b0}},
            // The unused opcode leaves the stack alone and reports its state.
            '{OP_NONE, 2'd1, 32'h0, 1, 1'b1, '{32'h0, ST_OK, 1'b0}},
            '{OP_NONE, 2'd2, 32'h0, 1, 1'b1, '{32'h0, ST_OK, 1'b1}},
            // A missing stack holds nothing and accepts nothing.
            '{OP_PUSH, SEL_MISSING, 32'h1234_5678, 1, 1'b1, '{32'h0, ST_OK, 1'b1}},
            '{OP_POP,  SEL_MISSING, 32'h0, 1, 1'b1, '{32'h0, ST_OK, 1'b1}},
            '{OP_PEEK, SEL_MISSING, 32'h0, 1, 1'b1, '{32'h0, ST_OK, 1'b1}},
            // Fill the last stack, then one push too many is dropped.
            '{OP_PUSH, 2'd2, 32'hA5A5_0000, STACK_DEPTH, 1'b0, '0},
            '{OP_PUSH, 2'd2, 32'h0, 1, 1'b1, '{32'h0, ST_FULL, 1'b0}},
            '{OP_PEEK, 2'd2, 32'h0, 1, 1'b0, '0},
            '{OP_POP,  2'd2, 32'h0, STACK_DEPTH, 1'b0, '0},
            '{OP_POP,  2'd2, 32'h0, 1, 1'b1, '{32'h0, ST_EMPTY, 1'b1}},
            '{OP_POP,  2'd1, 32'h0, 1, 1'b1, '{32'hFFFF_FFFF, ST_OK, 1'b1}},
            '{OP_PUSH, 2'd0, 32'h0, 1, 1'b1, '{32'h0, ST_OK, 1'b0}},
            '{OP_POP,  2'd0, 32'h0, 1, 1'b1, '{32'h0, ST_OK, 1'b1}}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part.
        idle_pct = 20;
        foreach (directed[r]) begin
            for (int i = 0; i < directed[r].reps; i++) begin
                send_op(directed[r].op, directed[r].sel, directed[r].val + VAL_W'(i),
                        directed[r].typed, directed[r].want);
            end
        end

        // Random part: fill runs, drain runs and mixed traffic in episodes.
        ops_done = 0;
        held     = 1'b0;
        drained  = 1'b0;
        while (ops_done < RANDOM_OPS) begin
            if (ops_done < 500) begin
                idle_pct = 25;
            end else if (ops_done < 900) begin
                idle_pct = 0;
                if (!held) begin
                    // Long receiver hold while items keep coming.
                    held = 1'b1;
                    hold_cycles = HOLD_LEN;
                end
            end else if (ops_done < 1400) begin
                idle_pct = 25;
                if (!drained) begin
                    // Sender pauses until every result is back.
                    drained = 1'b1;
                    req_ch.valid <= 1'b0;
                    while (pending_replies.size() != 0) @(posedge i_clk);
                end
            end else begin
                idle_pct = 0;
            end

            kind = $urandom_range(0, 9);
            s    = SEL_W'($urandom_range(0, NUM_STACKS - 1));
            if (kind < 3) begin
                // Push until the stack is full or overflows, then pop part of it back.
                n = STACK_DEPTH - stack_fill[s] + $urandom_range(0, 2);
                repeat (n) send_random(OP_PUSH, s);
                if ($urandom_range(0, 1)) send_random(OP_PEEK, s);
                repeat ($urandom_range(0, STACK_DEPTH)) send_random(OP_POP, s);
            end else if (kind < 5) begin
                // Pop until the stack underflows.
                n = stack_fill[s] + $urandom_range(1, 2);
                repeat (n) send_random(OP_POP, s);
            end else begin
                // Mixed traffic over all stacks, with some noise items.
                repeat (24) begin
                    n  = $urandom_range(0, 99);
                    s  = SEL_W'($urandom_range(0, NUM_STACKS - 1));
                    op = (n < 40) ? OP_PUSH : (n < 70) ? OP_POP :
                         (n < 88) ? OP_PEEK : OP_NONE;
                    if (n >= 95) begin
                        op = OP_W'($urandom_range(0, 3));
                        s  = SEL_MISSING;
                    end
                    send_random(op, s);
                end
            end
        end

        // Wind down.
        req_ch.valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[multi_stack_shared_memory_unit] OK");
        end else begin
            $display("[multi_stack_shared_memory_unit] ERROR");
        end
        $finish;
    end

endmodule
